### design/hmt_pkg.sv
// shared types, constants and helpers for the heartbeat membership table
package hmt_pkg;

	localparam int MEMBER_SLOTS = 16;
	localparam int IDX_W = $clog2(MEMBER_SLOTS);
	localparam int ADDR_W = 48;
	localparam int WORD_W = 32;
	localparam int SLOT_W = 4;
	localparam int STATUS_W = 4;

	typedef enum logic [1:0] {
		REG_SELF_ADDR = 2'd0,
		REG_TIMEOUT   = 2'd1,
		REG_CLEANUP   = 2'd2
	} reg_index_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_IGNORED    = 4'd0,
		STAT_JOINED     = 4'd1,
		STAT_UPDATED    = 4'd2,
		STAT_SPREAD     = 4'd3,
		STAT_SELF_LEAVE = 4'd4,
		STAT_FULL       = 4'd5,
		STAT_TIMED_OUT  = 4'd6,
		STAT_REMOVED    = 4'd7,
		STAT_SWEEP_DONE = 4'd8
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_HB_SCAN,
		S_HB_EMIT,
		S_SW_FAIL,
		S_SW_DROP,
		S_SW_DONE
	} back_state_t;

	typedef struct packed {
		logic [ADDR_W-1:0] self_addr;
		logic [WORD_W-1:0] timeout_ticks;
		logic [WORD_W-1:0] cleanup_ticks;
	} cfg_t;

	typedef struct packed {
		logic              cmd;
		logic [ADDR_W-1:0] addr;
		logic [WORD_W-1:0] inc;
		logic [WORD_W-1:0] hb;
		logic              failed;
		logic [WORD_W-1:0] now;
		logic              is_self;
	} item_t;

	typedef struct packed {
		status_t           status;
		logic [SLOT_W-1:0] slot;
		logic [ADDR_W-1:0] addr;
		logic [WORD_W-1:0] inc;
		logic              last;
	} res_t;

	// low bits of a slot index as the result field
	function automatic logic [SLOT_W-1:0] slot_field(input logic [IDX_W-1:0] idx);
		logic [IDX_W+SLOT_W-1:0] t;
		t = {{SLOT_W{1'b0}}, idx};
		return t[SLOT_W-1:0];
	endfunction

endpackage

### design/hmt_front.sv
// front end: item queue that tags heartbeat words naming this node
module hmt_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	output logic                    full,
	input  hmt_pkg::item_t          item_in,
	input  hmt_pkg::cfg_t           cfg,
	output logic                    valid,
	input  logic                    pop,
	output hmt_pkg::item_t          item_out
);

	hmt_pkg::item_t mem_q [2];
	logic           wr_q;
	logic           rd_q;
	logic [1:0]     count_q;
	hmt_pkg::item_t marked;
	logic           do_push;
	logic           do_pop;

	always_comb begin
		marked = item_in;
		marked.is_self = (item_in.addr == cfg.self_addr);
	end

	assign full     = (count_q == 2'd2);
	assign valid    = (count_q != 2'd0);
	assign do_push  = push && !full;
	assign do_pop   = pop && valid;
	assign item_out = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (do_push) wr_q <= ~wr_q;
			if (do_pop) rd_q <= ~rd_q;
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_q] <= marked;
	end

endmodule

### design/hmt_back.sv
// back end: table storage and the slot walking sequencer
module hmt_back (
	input  logic           clk,
	input  logic           arst_n,
	input  hmt_pkg::cfg_t  cfg,
	input  logic           in_valid,
	input  hmt_pkg::item_t item,
	output logic           in_pop,
	input  logic           res_full,
	output logic           res_push,
	output hmt_pkg::res_t  res
);

	localparam logic [hmt_pkg::IDX_W-1:0] LAST_IDX = hmt_pkg::IDX_W'(hmt_pkg::MEMBER_SLOTS - 1);

	hmt_pkg::back_state_t state_q, state_d;
	hmt_pkg::item_t       cur_q;
	logic [hmt_pkg::IDX_W-1:0] idx_q, idx_d, hit_q, hit_d, free_q, free_d;
	logic hit_found_q, hit_found_d, free_found_q, free_found_d;

	logic                        valid_q  [hmt_pkg::MEMBER_SLOTS];
	logic [hmt_pkg::ADDR_W-1:0]  addr_q   [hmt_pkg::MEMBER_SLOTS];
	logic [hmt_pkg::WORD_W-1:0]  inc_q    [hmt_pkg::MEMBER_SLOTS];
	logic [hmt_pkg::WORD_W-1:0]  hb_q     [hmt_pkg::MEMBER_SLOTS];
	logic [hmt_pkg::WORD_W-1:0]  seen_q   [hmt_pkg::MEMBER_SLOTS];
	logic                        failed_q [hmt_pkg::MEMBER_SLOTS];
	logic                        drop_q   [hmt_pkg::MEMBER_SLOTS];

	logic load, new_we, spread_we, hb_we, timeout_we, drop_we, drop_set, drop_val;
	logic live;
	logic [hmt_pkg::WORD_W-1:0] age;

	assign live = valid_q[idx_q] && (addr_q[idx_q] != cfg.self_addr);
	assign age  = cur_q.now - seen_q[idx_q];

	always_comb begin
		state_d      = state_q;
		idx_d        = idx_q;
		hit_d        = hit_q;
		free_d       = free_q;
		hit_found_d  = hit_found_q;
		free_found_d = free_found_q;
		in_pop       = 1'b0;
		load         = 1'b0;
		res_push     = 1'b0;
		new_we       = 1'b0;
		spread_we    = 1'b0;
		hb_we        = 1'b0;
		timeout_we   = 1'b0;
		drop_we      = 1'b0;
		drop_set     = 1'b0;
		drop_val     = 1'b0;
		res.status   = hmt_pkg::STAT_IGNORED;
		res.slot     = '0;
		res.addr     = cur_q.addr;
		res.inc      = cur_q.inc;
		res.last     = 1'b1;
		case (state_q)
			hmt_pkg::S_IDLE: begin
				if (in_valid) begin
					in_pop       = 1'b1;
					load         = 1'b1;
					idx_d        = '0;
					hit_found_d  = 1'b0;
					free_found_d = 1'b0;
					if (item.cmd) state_d = hmt_pkg::S_SW_FAIL;
					else if (item.is_self) state_d = hmt_pkg::S_HB_EMIT;
					else state_d = hmt_pkg::S_HB_SCAN;
				end
			end
			hmt_pkg::S_HB_SCAN: begin
				if (valid_q[idx_q]) begin
					if (!hit_found_q && addr_q[idx_q] == cur_q.addr
							&& inc_q[idx_q] == cur_q.inc) begin
						hit_found_d = 1'b1;
						hit_d       = idx_q;
					end
				end else if (!free_found_q) begin
					free_found_d = 1'b1;
					free_d       = idx_q;
				end
				if (idx_q == LAST_IDX) state_d = hmt_pkg::S_HB_EMIT;
				else idx_d = idx_q + 1'b1;
			end
			hmt_pkg::S_HB_EMIT: begin
				if (cur_q.is_self) begin
					if (cur_q.failed) res.status = hmt_pkg::STAT_SELF_LEAVE;
				end else if (!hit_found_q) begin
					if (!cur_q.failed) begin
						if (!free_found_q) res.status = hmt_pkg::STAT_FULL;
						else begin
							res.status = hmt_pkg::STAT_JOINED;
							res.slot   = hmt_pkg::slot_field(free_q);
							new_we     = !res_full;
						end
					end
				end else if (!failed_q[hit_q]) begin
					if (cur_q.failed) begin
						res.status = hmt_pkg::STAT_SPREAD;
						res.slot   = hmt_pkg::slot_field(hit_q);
						spread_we  = !res_full;
					end else if (cur_q.hb > hb_q[hit_q]) begin
						res.status = hmt_pkg::STAT_UPDATED;
						res.slot   = hmt_pkg::slot_field(hit_q);
						hb_we      = !res_full;
					end
				end
				if (!res_full) begin
					res_push = 1'b1;
					state_d  = hmt_pkg::S_IDLE;
				end
			end
			hmt_pkg::S_SW_FAIL: begin
				res.status = hmt_pkg::STAT_TIMED_OUT;
				res.slot   = hmt_pkg::slot_field(idx_q);
				res.addr   = addr_q[idx_q];
				res.inc    = inc_q[idx_q];
				res.last   = 1'b0;
				if (live && !failed_q[idx_q] && age > cfg.timeout_ticks) begin
					if (!res_full) begin
						res_push   = 1'b1;
						timeout_we = 1'b1;
					end
				end
				if (!(live && !failed_q[idx_q] && age > cfg.timeout_ticks) || !res_full) begin
					drop_set = 1'b1;
					drop_val = live && failed_q[idx_q] && age > cfg.cleanup_ticks;
					if (idx_q == LAST_IDX) begin
						state_d = hmt_pkg::S_SW_DROP;
						idx_d   = '0;
					end else idx_d = idx_q + 1'b1;
				end
			end
			hmt_pkg::S_SW_DROP: begin
				res.status = hmt_pkg::STAT_REMOVED;
				res.slot   = hmt_pkg::slot_field(idx_q);
				res.addr   = addr_q[idx_q];
				res.inc    = inc_q[idx_q];
				res.last   = 1'b0;
				if (drop_q[idx_q] && !res_full) begin
					res_push = 1'b1;
					drop_we  = 1'b1;
				end
				if (!drop_q[idx_q] || !res_full) begin
					if (idx_q == LAST_IDX) state_d = hmt_pkg::S_SW_DONE;
					else idx_d = idx_q + 1'b1;
				end
			end
			hmt_pkg::S_SW_DONE: begin
				res.status = hmt_pkg::STAT_SWEEP_DONE;
				res.addr   = '0;
				res.inc    = '0;
				if (!res_full) begin
					res_push = 1'b1;
					state_d  = hmt_pkg::S_IDLE;
				end
			end
			default: state_d = hmt_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= hmt_pkg::S_IDLE;
			idx_q        <= '0;
			hit_found_q  <= 1'b0;
			free_found_q <= 1'b0;
			for (int i = 0; i < hmt_pkg::MEMBER_SLOTS; i++) valid_q[i] <= 1'b0;
		end else begin
			state_q      <= state_d;
			idx_q        <= idx_d;
			hit_found_q  <= hit_found_d;
			free_found_q <= free_found_d;
			if (new_we) valid_q[free_q] <= 1'b1;
			if (drop_we) valid_q[idx_q] <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		hit_q  <= hit_d;
		free_q <= free_d;
		if (load) cur_q <= item;
		if (drop_set) drop_q[idx_q] <= drop_val;
		if (new_we) begin
			addr_q[free_q]   <= cur_q.addr;
			inc_q[free_q]    <= cur_q.inc;
			hb_q[free_q]     <= cur_q.hb;
			seen_q[free_q]   <= cur_q.now;
			failed_q[free_q] <= 1'b0;
		end
		if (spread_we) begin
			failed_q[hit_q] <= 1'b1;
			seen_q[hit_q]   <= cur_q.now;
		end
		if (hb_we) begin
			hb_q[hit_q]   <= cur_q.hb;
			seen_q[hit_q] <= cur_q.now;
		end
		if (timeout_we) begin
			failed_q[idx_q] <= 1'b1;
			seen_q[idx_q]   <= cur_q.now;
		end
	end

endmodule

### design/hmt_outq.sv
// result queue between the sequencer and the result ports
module hmt_outq (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  hmt_pkg::res_t res_in,
	output logic          full,
	input  logic          pop,
	output logic          empty,
	output hmt_pkg::res_t res_out
);

	hmt_pkg::res_t mem_q [2];
	logic          wr_q;
	logic          rd_q;
	logic [1:0]    count_q;
	logic          do_push;
	logic          do_pop;

	assign full    = (count_q == 2'd2);
	assign empty   = (count_q == 2'd0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign res_out = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (do_push) wr_q <= ~wr_q;
			if (do_pop) rd_q <= ~rd_q;
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_q] <= res_in;
	end

endmodule

### design/heartbeat_membership_table.sv
// top level of the heartbeat membership table
//
//  channel   handshake         payload
//  input     push / full       cmd peer_addr peer_incarnation peer_heartbeat
//                              peer_failed current_time
//  result    empty / pop       status slot out_addr out_incarnation last
//  config    cfg_we            cfg_index cfg_data
//
// a heartbeat word is matched against every slot in the sequencer (one slot
// read per cycle in the table scan), a word naming this node skips the scan
// a sweep walks the table in two passes, time-outs and then removals, each one
// slot per cycle unless a result waits on a full result queue
// reset clears the table valid bits and both queues at once, no clearing pass
// a two word queue on each side lets pushing and popping stall independently
module heartbeat_membership_table (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration
	input  logic                            cfg_we,
	input  logic [1:0]                      cfg_index,
	input  logic [hmt_pkg::ADDR_W-1:0]      cfg_data,
	// input words
	input  logic                            push,
	output logic                            full,
	input  logic                            cmd,
	input  logic [hmt_pkg::ADDR_W-1:0]      peer_addr,
	input  logic [hmt_pkg::WORD_W-1:0]      peer_incarnation,
	input  logic [hmt_pkg::WORD_W-1:0]      peer_heartbeat,
	input  logic                            peer_failed,
	input  logic [hmt_pkg::WORD_W-1:0]      current_time,
	// result words
	output logic                            empty,
	input  logic                            pop,
	output logic [hmt_pkg::STATUS_W-1:0]    status,
	output logic [hmt_pkg::SLOT_W-1:0]      slot,
	output logic [hmt_pkg::ADDR_W-1:0]      out_addr,
	output logic [hmt_pkg::WORD_W-1:0]      out_incarnation,
	output logic                            last
);

	hmt_pkg::cfg_t  cfg_q;
	hmt_pkg::item_t item_in;
	hmt_pkg::item_t item_q;
	hmt_pkg::res_t  res_w;
	hmt_pkg::res_t  head;
	logic           item_valid;
	logic           item_pop;
	logic           res_push;
	logic           res_full;

	// configuration registers, unknown indexes fall through untouched
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.self_addr     <= '0;
			cfg_q.timeout_ticks <= hmt_pkg::WORD_W'(5);
			cfg_q.cleanup_ticks <= hmt_pkg::WORD_W'(10);
		end else if (cfg_we) begin
			case (cfg_index)
				hmt_pkg::REG_SELF_ADDR: cfg_q.self_addr     <= cfg_data;
				hmt_pkg::REG_TIMEOUT:   cfg_q.timeout_ticks <= cfg_data[hmt_pkg::WORD_W-1:0];
				hmt_pkg::REG_CLEANUP:   cfg_q.cleanup_ticks <= cfg_data[hmt_pkg::WORD_W-1:0];
				default:                cfg_q               <= cfg_q;
			endcase
		end
	end

	// gather the input word, the self tag is filled in by the front end
	always_comb begin
		item_in.cmd     = cmd;
		item_in.addr    = peer_addr;
		item_in.inc     = peer_incarnation;
		item_in.hb      = peer_heartbeat;
		item_in.failed  = peer_failed;
		item_in.now     = current_time;
		item_in.is_self = 1'b0;
	end

	hmt_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.item_in  (item_in),
		.cfg      (cfg_q),
		.valid    (item_valid),
		.pop      (item_pop),
		.item_out (item_q)
	);

	hmt_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (item_valid),
		.item     (item_q),
		.in_pop   (item_pop),
		.res_full (res_full),
		.res_push (res_push),
		.res      (res_w)
	);

	hmt_outq u_outq (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (res_push),
		.res_in  (res_w),
		.full    (res_full),
		.pop     (pop),
		.empty   (empty),
		.res_out (head)
	);

	// result ports straight off the queue head
	assign status          = head.status;
	assign slot            = head.slot;
	assign out_addr        = head.addr;
	assign out_incarnation = head.inc;
	assign last            = head.last;

endmodule

### design/hmt_checker.sv
// port level checks for the heartbeat membership table
module hmt_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         empty,
	input logic                         pop,
	input logic [hmt_pkg::STATUS_W-1:0] status,
	input logic [hmt_pkg::SLOT_W-1:0]   slot,
	input logic [hmt_pkg::ADDR_W-1:0]   out_addr,
	input logic                         last
);

	// only sweep done closes a sweep, every heartbeat result is final
	a_last_code: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (last == (status != hmt_pkg::STAT_TIMED_OUT
			&& status != hmt_pkg::STAT_REMOVED)))
		else $error("last flag does not match status");

	a_done_blank: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status == hmt_pkg::STAT_SWEEP_DONE) |-> (slot == '0 && out_addr == '0))
		else $error("sweep done carries a slot or address");

	a_known_code: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (status <= hmt_pkg::STAT_SWEEP_DONE))
		else $error("status out of range");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(status) && $stable(slot)))
		else $error("waiting result word changed");

endmodule

bind heartbeat_membership_table hmt_checker u_hmt_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.empty    (empty),
	.pop      (pop),
	.status   (status),
	.slot     (slot),
	.out_addr (out_addr),
	.last     (last)
);

### sim/heartbeat_membership_table_tb.sv
// self-checking testbench for the heartbeat membership table
`timescale 1ns / 100ps

module heartbeat_membership_table_tb;
	import hmt_pkg::*;

	localparam logic [1:0] REG_SPARE = 2'd3; // index with no register behind it
	localparam int CYCLE_LIMIT = 600000;
	localparam int RAND_WORDS = 56; // per configuration phase
	localparam int POOL = 24;

	// one input word plus an optional hand-typed expectation
	typedef struct {
		logic              cmd;
		logic [ADDR_W-1:0] addr;
		logic [WORD_W-1:0] inc;
		logic [WORD_W-1:0] hb;
		logic              failed;
		logic [WORD_W-1:0] now;
		bit                typed;
		status_t           exp_status;
		logic [SLOT_W-1:0] exp_slot;
	} hb_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [ADDR_W-1:0] cfg_data = '0;
	logic push = 1'b0;
	logic full;
	logic cmd = 1'b0;
	logic [ADDR_W-1:0] peer_addr = '0;
	logic [WORD_W-1:0] peer_incarnation = '0;
	logic [WORD_W-1:0] peer_heartbeat = '0;
	logic peer_failed = 1'b0;
	logic [WORD_W-1:0] current_time = '0;
	logic empty;
	logic pop = 1'b0;
	logic [STATUS_W-1:0] status;
	logic [SLOT_W-1:0] slot;
	logic [ADDR_W-1:0] out_addr;
	logic [WORD_W-1:0] out_incarnation;
	logic last;

	heartbeat_membership_table dut (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// shadow copy of the membership table and its registers
	logic [ADDR_W-1:0] self_q;
	logic [WORD_W-1:0] timeout_q, cleanup_q;
	bit                mem_valid [MEMBER_SLOTS];
	logic [ADDR_W-1:0] mem_addr [MEMBER_SLOTS];
	logic [WORD_W-1:0] mem_inc [MEMBER_SLOTS];
	logic [WORD_W-1:0] mem_hb [MEMBER_SLOTS];
	logic [WORD_W-1:0] mem_seen [MEMBER_SLOTS];
	bit                mem_failed [MEMBER_SLOTS];

	res_t     pending_results[$];
	hb_word_t word_on_port;
	int       mismatches = 0;
	int       words_in = 0, results_out = 0, sweeps = 0, removals = 0, table_full = 0;
	int       cycles = 0;
	int       send_idle = 25, recv_idle = 65;
	int       gap_next = 1;

	function automatic res_t mk_res(status_t st, int idx, logic [ADDR_W-1:0] a,
			logic [WORD_W-1:0] i, logic l);
		res_t r;
		r.status = st;
		r.slot = idx[SLOT_W-1:0];
		r.addr = a;
		r.inc = i;
		r.last = l;
		return r;
	endfunction

	// append one expected result word at the tail
	function automatic void expect_word(res_t r);
		pending_results.insert(pending_results.size(), r);
	endfunction

	// merge one received entry, or sweep, and queue what the block must return
	function automatic void predict_membership(hb_word_t w);
		int hit, free_idx;
		bit drop [MEMBER_SLOTS];
		if (w.cmd) begin
			sweeps++;
			for (int k = 0; k < MEMBER_SLOTS; k++) begin
				drop[k] = 0;
				if (!mem_valid[k] || mem_addr[k] == self_q) continue;
				if (!mem_failed[k]) begin
					if (WORD_W'(w.now - mem_seen[k]) > timeout_q) begin
						mem_failed[k] = 1;
						mem_seen[k] = w.now;
						expect_word(mk_res(STAT_TIMED_OUT, k, mem_addr[k],
							mem_inc[k], 1'b0));
					end
				end else if (WORD_W'(w.now - mem_seen[k]) > cleanup_q) begin
					drop[k] = 1;
				end
			end
			for (int k = 0; k < MEMBER_SLOTS; k++)
				if (drop[k]) begin
					mem_valid[k] = 0;
					removals++;
					expect_word(mk_res(STAT_REMOVED, k, mem_addr[k],
						mem_inc[k], 1'b0));
				end
			expect_word(mk_res(STAT_SWEEP_DONE, 0, '0, '0, 1'b1));
			return;
		end
		if (w.typed) begin
			// expectation read straight off the row, table still tracked below
			expect_word(mk_res(w.exp_status, w.exp_slot, w.addr, w.inc, 1'b1));
		end
		if (w.addr == self_q) begin
			if (!w.typed)
				expect_word(mk_res(w.failed ? STAT_SELF_LEAVE : STAT_IGNORED,
					0, w.addr, w.inc, 1'b1));
			return;
		end
		hit = -1;
		free_idx = -1;
		for (int k = 0; k < MEMBER_SLOTS; k++)
			if (mem_valid[k]) begin
				if (hit < 0 && mem_addr[k] == w.addr && mem_inc[k] == w.inc) hit = k;
			end else if (free_idx < 0) begin
				free_idx = k;
			end
		if (hit < 0) begin
			if (w.failed) begin
				if (!w.typed) expect_word(mk_res(STAT_IGNORED, 0, w.addr, w.inc, 1));
			end else if (free_idx < 0) begin
				table_full++;
				if (!w.typed) expect_word(mk_res(STAT_FULL, 0, w.addr, w.inc, 1));
			end else begin
				mem_valid[free_idx] = 1;
				mem_addr[free_idx] = w.addr;
				mem_inc[free_idx] = w.inc;
				mem_hb[free_idx] = w.hb;
				mem_seen[free_idx] = w.now;
				mem_failed[free_idx] = 0;
				if (!w.typed)
					expect_word(mk_res(STAT_JOINED, free_idx, w.addr, w.inc, 1));
			end
		end else if (mem_failed[hit]) begin
			if (!w.typed) expect_word(mk_res(STAT_IGNORED, 0, w.addr, w.inc, 1));
		end else if (w.failed) begin
			mem_failed[hit] = 1;
			mem_seen[hit] = w.now;
			if (!w.typed) expect_word(mk_res(STAT_SPREAD, hit, w.addr, w.inc, 1));
		end else if (w.hb > mem_hb[hit]) begin
			mem_hb[hit] = w.hb;
			mem_seen[hit] = w.now;
			if (!w.typed) expect_word(mk_res(STAT_UPDATED, hit, w.addr, w.inc, 1));
		end else begin
			if (!w.typed) expect_word(mk_res(STAT_IGNORED, 0, w.addr, w.inc, 1));
		end
	endfunction

	task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
		$display("mismatch on word %0d: %s got %0h expected %0h", results_out, field, got, want);
		mismatches++;
	endtask

	// input side: every accepted word goes through the predictor
	always @(posedge clk)
		if (arst_n && push && !full) begin
			words_in++;
			predict_membership(word_on_port);
		end

	// result side: check the popped word, then decide on the next stall
	always @(posedge clk) begin
		cycles++;
		if (arst_n && pop && !empty) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected word, status", status, 0);
			end else begin
				res_t want;
				want = pending_results.pop_front();
				if (status !== want.status) report_mismatch("status", status, want.status);
				if (slot !== want.slot) report_mismatch("slot", slot, want.slot);
				if (out_addr !== want.addr) report_mismatch("out_addr", out_addr, want.addr);
				if (out_incarnation !== want.inc)
					report_mismatch("out_incarnation", out_incarnation, want.inc);
				if (last !== want.last) report_mismatch("last", last, want.last);
			end
			results_out++;
		end
		pop <= ($urandom_range(0, 99) >= recv_idle);
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("end of test: mismatches");
			$finish;
		end
	end

	// drive one word and hold it until the block takes it
	task automatic send_word(hb_word_t w, bit hold_after);
		int g;
		repeat (gap_next) @(posedge clk);
		word_on_port <= w;
		cmd <= w.cmd;
		peer_addr <= w.addr;
		peer_incarnation <= w.inc;
		peer_heartbeat <= w.hb;
		peer_failed <= w.failed;
		current_time <= w.now;
		push <= 1'b1;
		do @(posedge clk); while (full);
		g = ($urandom_range(0, 99) < send_idle) ? $urandom_range(1, 4) : 0;
		// lower push here only, so it never gets two assignments in one step
		if (!hold_after || g > 0) begin
			push <= 1'b0;
			gap_next = (g > 0) ? g : 1;
		end else begin
			gap_next = 0;
		end
	endtask

	// registers only change once the block has drained
	task automatic write_reg(reg_index_t idx, logic [ADDR_W-1:0] val);
		wait (pending_results.size() == 0);
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_SELF_ADDR: self_q = val;
			REG_TIMEOUT:   timeout_q = val[WORD_W-1:0];
			REG_CLEANUP:   cleanup_q = val[WORD_W-1:0];
			default: ;
		endcase
		gap_next = 1;
	endtask

	function automatic hb_word_t row(logic c, logic [ADDR_W-1:0] a, logic [WORD_W-1:0] i,
			logic [WORD_W-1:0] h, logic f, logic [WORD_W-1:0] n, bit t,
			status_t st, logic [SLOT_W-1:0] sl);
		hb_word_t w;
		w.cmd = c; w.addr = a; w.inc = i; w.hb = h; w.failed = f; w.now = n;
		w.typed = t; w.exp_status = st; w.exp_slot = sl;
		return w;
	endfunction

	hb_word_t directed [$];
	logic [ADDR_W-1:0] pool_addr [POOL];
	logic [WORD_W-1:0] pool_inc [POOL];
	logic [WORD_W-1:0] pool_hb [POOL];
	logic [WORD_W-1:0] clock_now;

	// append one row to the directed table
	function automatic void add_row(hb_word_t w);
		directed.insert(directed.size(), w);
	endfunction

	initial begin
		hb_word_t w;
		logic [63:0] wide;
		int p;
		self_q = '0;
		timeout_q = 5;
		cleanup_q = 10;
		foreach (mem_valid[k]) mem_valid[k] = 0;
		for (int k = 0; k < POOL; k++) begin
			wide = {$urandom, $urandom};
			pool_addr[k] = wide[ADDR_W-1:0];
			pool_inc[k] = ($urandom_range(0, 1)) ? $urandom : $urandom_range(0, 3);
			pool_hb[k] = $urandom_range(0, 50);
		end
		pool_addr[1] = '1;
		pool_addr[2] = 48'd1;

		// directed rows: reset registers, self address is zero
		add_row(row(0, '0, 32'h1234, 0, 0, 0, 1, STAT_IGNORED, 0));
		add_row(row(0, '0, '1, '1, 1, 0, 1, STAT_SELF_LEAVE, 0));
		add_row(row(0, '1, '1, '1, 0, 100, 1, STAT_JOINED, 0));
		add_row(row(0, '1, '1, 32'h7fff_ffff, 0, 100, 1, STAT_IGNORED, 0));
		add_row(row(0, 48'd1, 0, 0, 0, 100, 1, STAT_JOINED, 1));
		add_row(row(0, 48'd1, 0, 5, 0, 101, 1, STAT_UPDATED, 1));
		add_row(row(0, 48'd2, 0, 5, 1, 101, 1, STAT_IGNORED, 0));
		add_row(row(0, 48'd1, 0, 5, 1, 102, 1, STAT_SPREAD, 1));
		add_row(row(0, 48'd1, 0, 9, 0, 102, 1, STAT_IGNORED, 0));
		add_row(row(0, 48'd1, 1, 0, 0, 102, 1, STAT_JOINED, 2)); // restarted peer
		// sweeps: nothing due, then time-outs and removals, then a wrapped clock
		add_row(row(1, '1, '1, '1, 1, 103, 0, STAT_IGNORED, 0));
		add_row(row(1, '0, '0, '0, 0, 200, 0, STAT_IGNORED, 0));
		add_row(row(1, '0, '0, '0, 0, 300, 0, STAT_IGNORED, 0));
		add_row(row(0, 48'h8000_0000_0000, '1, 3, 0, '1, 0, STAT_IGNORED, 0));
		add_row(row(1, '0, '0, '0, 0, 32'd2, 0, STAT_IGNORED, 0));
		// fill the table, then one new peer too many
		for (int k = 0; k < MEMBER_SLOTS; k++)
			add_row(row(0, 48'h100 + k, k, 1, 0, 400, 0, STAT_IGNORED, 0));
		add_row(row(0, 48'h5555_aaaa_0000, 7, 1, 0, 400, 1, STAT_FULL, 0));
		add_row(row(1, '0, '0, '0, 0, 401, 0, STAT_IGNORED, 0));
		add_row(row(1, '0, '0, '0, 0, 500, 0, STAT_IGNORED, 0));
		add_row(row(1, '0, '0, '0, 0, 600, 0, STAT_IGNORED, 0));

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[k]) send_word(directed[k], k != directed.size() - 1);

		// random phases, each after a fresh set of registers
		clock_now = 1000;
		for (int ph = 0; ph < 4; ph++) begin
			wait (pending_results.size() == 0);
			case (ph)
				0: begin
					write_reg(REG_SELF_ADDR, pool_addr[0]);
					write_reg(REG_TIMEOUT, 3);
					write_reg(REG_CLEANUP, 6);
				end
				1: begin
					write_reg(REG_SELF_ADDR, '1);
					write_reg(REG_TIMEOUT, 0);
					write_reg(REG_CLEANUP, 0);
					write_reg(reg_index_t'(REG_SPARE), 48'h0);
				end
				2: begin
					write_reg(REG_SELF_ADDR, pool_addr[5]);
					write_reg(REG_TIMEOUT, '1);
					write_reg(REG_CLEANUP, '1);
				end
				default: begin
					wide = {$urandom, $urandom};
					write_reg(REG_SELF_ADDR, wide[ADDR_W-1:0]);
					write_reg(REG_TIMEOUT, $urandom_range(2, 12));
					write_reg(REG_CLEANUP, $urandom_range(2, 20));
				end
			endcase
			for (int n = 0; n < RAND_WORDS; n++) begin
				// idling pattern follows progress through the whole run
				if (ph * RAND_WORDS + n == 52) begin
					send_idle = 65;
					recv_idle = 25;
				end else if (ph * RAND_WORDS + n == 138) begin
					send_idle = 0;
					recv_idle = 0;
				end
				p = $urandom_range(0, POOL - 1);
				clock_now += $urandom_range(0, 4);
				if ($urandom_range(0, 39) == 0) clock_now = $urandom;
				w = row(0, pool_addr[p], pool_inc[p], '0, 0, clock_now, 0, STAT_IGNORED, 0);
				w.cmd = ($urandom_range(0, 99) < 15);
				if (!w.cmd) begin
					pool_hb[p] += $urandom_range(0, 3);
					w.hb = pool_hb[p];
					w.failed = ($urandom_range(0, 9) == 0);
					if ($urandom_range(0, 7) == 0) w.inc = $urandom;
					if ($urandom_range(0, 15) == 0) w.hb = $urandom;
					if ($urandom_range(0, 19) == 0) w.addr = self_q;
				end else begin
					// sweep fields other than the clock are don't-care noise
					wide = {$urandom, $urandom};
					w.addr = wide[ADDR_W-1:0];
					w.inc = $urandom;
					w.hb = $urandom;
					w.failed = $urandom_range(0, 1);
				end
				send_word(w, n != RAND_WORDS - 1);
			end
		end

		wait (pending_results.size() == 0);
		repeat (60) @(posedge clk);
		$display("covered %0d words in, %0d results out, %0d sweeps", words_in, results_out,
			sweeps);
		$display("%0d peers removed, %0d joins refused on a full table", removals, table_full);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

### heartbeat_membership_table.f
design/hmt_pkg.sv
design/hmt_front.sv
design/hmt_back.sv
design/hmt_outq.sv
design/heartbeat_membership_table.sv
design/hmt_checker.sv
sim/heartbeat_membership_table_tb.sv
